// File: design/mbdc_pkg.sv
package mbdc_pkg;

	// defaults for the top level parameters
	localparam int BURST_LENGTH_DEF  = 64;
	localparam int DC_POLE_SHIFT_DEF = 4;

	// divider geometry: 32-bit dividend, 16-bit divisor, one quotient bit per cycle
	localparam int DIV_STEPS    = 32;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

	// configuration register reset values
	localparam logic [15:0] SOURCE_RATE_RST = 16'd16000;
	localparam logic [15:0] OUTPUT_RATE_RST = 16'd8000;
	localparam logic [15:0] MAX_SAMPLES_RST = 16'd49152;

	// sample clamp limits
	localparam logic signed [16:0] CLAMP_HI = 17'sd32767;
	localparam logic signed [16:0] CLAMP_LO = -17'sd32768;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SOURCE_RATE = 2'd0;
	localparam logic [1:0] REG_OUTPUT_RATE = 2'd1;
	localparam logic [1:0] REG_MAX_SAMPLES = 2'd2;

	// input action codes
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_STOP   = 2'd2;

	// capture mode
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_BURST = 2'd1,
		MODE_RUN   = 2'd2
	} mode_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_READY,
		ST_BIAS,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_DC,
		ST_EMIT
	} seq_state_t;

	// divider request and response
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

// File: design/mbdc_div.sv
module mbdc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mbdc_pkg::div_req_t req,
	output mbdc_pkg::div_rsp_t rsp
);
	import mbdc_pkg::*;

	logic [15:0]          rem_q;
	logic [31:0]          quo_q;
	logic [15:0]          divisor_q;
	logic [DIV_CNT_W-1:0] count_q;
	logic                 busy_q;
	logic                 done_q;
	logic [16:0]          shifted;
	logic [16:0]          trial;
	logic                 qbit;

	// one restoring step: shift in the next dividend bit and try the subtract
	always_comb begin
		shifted = {rem_q, quo_q[31]};
		trial   = shifted - {1'b0, divisor_q};
		qbit    = (shifted >= {1'b0, divisor_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q  <= 1'b1;
				count_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in where the dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[15:0] : shifted[15:0];
			quo_q <= {quo_q[30:0], qbit};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

`ifndef SYNTHESIS
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
	a_start_runs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && !busy_q) |=> busy_q && count_q == DIV_CNT_W'(DIV_STEPS))
		else $error("divider did not load a full step count");
	a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < divisor_q || divisor_q == 16'd0)
		else $error("partial remainder not below divisor");
`endif

endmodule

// File: design/mic_bias_decimate_dc_block_top.sv
// Microphone front end: bias removal, boxcar decimation and DC blocking.
// Input stream (s_*): one transaction per item; s_tuser carries the action
// (sample, start capture, stop capture), s_tdata the unsigned ADC value.
// A start opens a capture; the next BURST_LENGTH samples are averaged into a
// bias level. Later samples are bias-corrected, clamped to 16 bits and summed
// until the rate phase accumulator says an output is due; the window mean then
// updates a one-pole DC tracker and the DC-removed value goes out on m_*.
// Output stream (m_*): m_tdata = {sample_number, sample}, m_tlast marks the
// output that reaches max_samples and ends the capture.
// Sequencing: an item that produces no result and does not finish the bias burst
// leaves the block ready. The last burst sample adds the bias state (reciprocal
// multiply for the bias). A due sample runs the 32-step serial divider for the
// mean, then the DC and emit states; s_tready returns with the result on m_*.
// The output is a register: the next item is accepted while a result waits;
// a further result waits in the sequencer until m_tready frees the register.
// Registers (APB, always ready): source_rate at 0x0, output_rate at 0x4,
// max_samples at 0x8; write them only while the block is idle.
// Reset clears the capture state, drops any pending result and restores the
// register defaults; the block is ready as soon as reset is released.
module mic_bias_decimate_dc_block_top #(
	parameter int BURST_LENGTH  = mbdc_pkg::BURST_LENGTH_DEF,
	parameter int DC_POLE_SHIFT = mbdc_pkg::DC_POLE_SHIFT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] adc_value
	input  logic [1:0]  s_tuser,   // [1:0] action
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] sample, [31:16] sample_number
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mbdc_pkg::*;

	localparam int BCNT_W = $clog2(BURST_LENGTH + 1);
	localparam int BSUM_W = 16 + $clog2(BURST_LENGTH);

	// exact reciprocal for the bias division over the whole bias sum range
	localparam int          RECIP_SH = BSUM_W + $clog2(BURST_LENGTH);
	localparam int          RECIP_W  = BSUM_W + 1;
	localparam int          PROD_W   = BSUM_W + RECIP_W;
	localparam logic [63:0] RECIP    = ((64'd1 << RECIP_SH) + 64'(BURST_LENGTH) - 64'd1)
		/ 64'(BURST_LENGTH);

	// configuration registers
	logic [15:0] source_rate_q;
	logic [15:0] output_rate_q;
	logic [15:0] max_samples_q;
	logic        cfg_wr;

	// capture state
	mode_t              mode_q;
	seq_state_t         state_q;
	seq_state_t         state_d;
	logic [BCNT_W-1:0]  burst_count_q;
	logic [BSUM_W-1:0]  bias_sum_q;
	logic [15:0]        bias_level_q;
	logic signed [31:0] window_sum_q;
	logic [15:0]        window_count_q;
	logic [16:0]        rate_phase_q;
	logic signed [24:0] dc_level_q;
	logic [15:0]        stored_count_q;
	logic signed [15:0] mean_q;
	logic               sum_neg_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_sample_q;
	logic [15:0] out_number_q;
	logic        out_last_q;

	// sequencer outputs
	logic     accept;
	logic     emit;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// item decode and per-sample arithmetic
	logic [1:0]         action;
	logic [15:0]        adc_value;
	logic [BCNT_W-1:0]  burst_count_inc;
	logic               burst_done;
	logic [PROD_W-1:0]  bias_prod;
	logic [15:0]        bias_mean;
	logic signed [16:0] diff;
	logic signed [15:0] clamped;
	logic [16:0]        phase_sum;
	logic [16:0]        phase_sub;
	logic [16:0]        phase_next;
	logic               due;
	logic               run_sample;
	logic [31:0]        sum_mag;
	logic [16:0]        mean_wide;
	logic signed [25:0] dc_diff;
	logic signed [25:0] dc_step;
	logic signed [16:0] dc_int;
	logic [15:0]        result;
	logic [15:0]        count_next;
	logic               last_next;

	assign action    = s_tuser;
	assign adc_value = s_tdata;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_rate_q <= SOURCE_RATE_RST;
			output_rate_q <= OUTPUT_RATE_RST;
			max_samples_q <= MAX_SAMPLES_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SOURCE_RATE: source_rate_q <= pwdata[15:0];
				REG_OUTPUT_RATE: output_rate_q <= pwdata[15:0];
				REG_MAX_SAMPLES: max_samples_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SOURCE_RATE: prdata = {16'd0, source_rate_q};
			REG_OUTPUT_RATE: prdata = {16'd0, output_rate_q};
			REG_MAX_SAMPLES: prdata = {16'd0, max_samples_q};
			default:         prdata = 32'd0;
		endcase
	end

	// burst progress
	always_comb begin
		burst_count_inc = burst_count_q + 1'b1;
		burst_done      = (burst_count_inc >= BCNT_W'(BURST_LENGTH));
	end

	// bias level: burst sum times the scaled reciprocal of the burst length
	always_comb begin
		bias_prod = PROD_W'(bias_sum_q) * PROD_W'(RECIP[RECIP_W-1:0]);
		bias_mean = bias_prod[RECIP_SH +: 16];
	end

	// bias correction with clamp to int16
	always_comb begin
		diff = $signed({1'b0, adc_value}) - $signed({1'b0, bias_level_q});
		if (diff > CLAMP_HI) begin
			clamped = CLAMP_HI[15:0];
		end else if (diff < CLAMP_LO) begin
			clamped = CLAMP_LO[15:0];
		end else begin
			clamped = diff[15:0];
		end
	end

	// rate phase accumulator
	always_comb begin
		phase_sum  = rate_phase_q + {1'b0, output_rate_q};
		phase_sub  = phase_sum - {1'b0, source_rate_q};
		due        = 1'b0;
		phase_next = phase_sum;
		if (source_rate_q == 16'd0) begin
			due        = 1'b1;
			phase_next = '0;
		end else if (phase_sum >= {1'b0, source_rate_q}) begin
			due = 1'b1;
			if (phase_sub >= {1'b0, source_rate_q}) begin
				phase_next = {1'b0, source_rate_q} - 17'd1;
			end else begin
				phase_next = phase_sub;
			end
		end
	end

	assign run_sample = (action == ACT_SAMPLE) && (mode_q == MODE_RUN);

	// mean sign restore and DC tracker arithmetic
	always_comb begin
		sum_mag   = window_sum_q[31] ? 32'(-window_sum_q) : 32'(window_sum_q);
		mean_wide = sum_neg_q ? (17'd0 - div_rsp.quotient[16:0]) : div_rsp.quotient[16:0];
		dc_diff   = $signed({{2{mean_q[15]}}, mean_q, 8'd0}) - $signed({dc_level_q[24], dc_level_q});
		dc_step   = dc_diff >>> DC_POLE_SHIFT;
		dc_int    = 17'(dc_level_q >>> 8);
		result    = mean_q - dc_int[15:0];
		count_next = stored_count_q + 16'd1;
		last_next  = (count_next >= max_samples_q) || (count_next == 16'd0);
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_READY: begin
				if (s_tvalid && action == ACT_SAMPLE) begin
					if (mode_q == MODE_BURST && burst_done) begin
						state_d = ST_BIAS;
					end else if (mode_q == MODE_RUN && due) begin
						state_d = ST_MEAN_GO;
					end
				end
			end
			ST_BIAS:      state_d = ST_READY;
			ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
			ST_MEAN_WAIT: if (div_rsp.done) state_d = ST_DC;
			ST_DC:        state_d = ST_EMIT;
			ST_EMIT:      if (!out_valid_q || m_tready) state_d = ST_READY;
			default:      state_d = ST_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: outputs
	always_comb begin
		s_tready         = 1'b0;
		emit             = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = sum_mag;
		div_req.divisor  = window_count_q;
		case (state_q)
			ST_READY:   s_tready = 1'b1;
			ST_MEAN_GO: div_req.start = 1'b1;
			ST_EMIT:    emit = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// serial divider for the window mean
	mbdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// capture state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			burst_count_q  <= '0;
			bias_sum_q     <= '0;
			bias_level_q   <= '0;
			window_sum_q   <= '0;
			window_count_q <= '0;
			rate_phase_q   <= '0;
			dc_level_q     <= '0;
			stored_count_q <= '0;
			mean_q         <= '0;
			sum_neg_q      <= 1'b0;
		end else begin
			if (accept) begin
				case (action)
					ACT_START: begin
						mode_q         <= MODE_BURST;
						burst_count_q  <= '0;
						bias_sum_q     <= '0;
						bias_level_q   <= '0;
						window_sum_q   <= '0;
						window_count_q <= '0;
						rate_phase_q   <= '0;
						dc_level_q     <= '0;
						stored_count_q <= '0;
					end
					ACT_STOP: mode_q <= MODE_IDLE;
					ACT_SAMPLE: begin
						if (mode_q == MODE_BURST) begin
							bias_sum_q    <= bias_sum_q + BSUM_W'(adc_value);
							burst_count_q <= burst_count_inc;
						end else if (run_sample) begin
							if (window_count_q != 16'hFFFF) begin
								window_sum_q   <= window_sum_q + 32'(clamped);
								window_count_q <= window_count_q + 16'd1;
							end
							rate_phase_q <= phase_next;
						end
					end
					default: ;
				endcase
			end
			// bias ready: switch to running
			if (state_q == ST_BIAS) begin
				bias_level_q <= bias_mean;
				mode_q       <= MODE_RUN;
			end
			if (state_q == ST_MEAN_GO) begin
				sum_neg_q <= window_sum_q[31];
			end
			if (state_q == ST_MEAN_WAIT && div_rsp.done) begin
				mean_q <= mean_wide[15:0];
			end
			if (state_q == ST_DC) begin
				dc_level_q <= dc_level_q + dc_step[24:0];
			end
			if (emit) begin
				window_sum_q   <= '0;
				window_count_q <= '0;
				stored_count_q <= count_next;
				if (last_next) begin
					mode_q <= MODE_IDLE;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_sample_q <= result;
			out_number_q <= stored_count_q;
			out_last_q   <= last_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_number_q, out_sample_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_ready_divider_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READY |-> !div_rsp.busy)
		else $error("sequencer ready while divider busy");
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_MEAN_WAIT)
		else $error("divider result arrived outside a wait state");
	a_mean_nonzero_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MEAN_GO |-> window_count_q != 16'd0)
		else $error("mean division with empty window");
	a_last_ends_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_next) |=> mode_q == MODE_IDLE && m_tvalid && m_tlast)
		else $error("final output did not end the capture");
	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !out_valid_q || m_tready)
		else $error("result overwrote a pending output");
`endif

endmodule

// File: tb/tb_mic_bias_decimate_dc_block_top.sv
`timescale 1ns / 1ps

module tb_mic_bias_decimate_dc_block_top;
	import mbdc_pkg::*;

	localparam int BURST_LEN  = BURST_LENGTH_DEF;
	localparam int POLE_SHIFT = DC_POLE_SHIFT_DEF;
	// unused action code, the block must ignore it
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	// cycles a no-result item may still be busy after the last output
	localparam int SETTLE_CYCLES = 80;

	typedef struct packed {
		logic [1:0]  act;
		logic [15:0] adc;
	} mic_item_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [15:0] index;
		logic        last;
	} mic_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] adc_value
	logic [1:0]  s_tuser = '0;   // [1:0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [15:0] sample, [31:16] sample_number
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	mic_bias_decimate_dc_block_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow registers
	logic [15:0] src_rate = SOURCE_RATE_RST;
	logic [15:0] out_rate = OUTPUT_RATE_RST;
	logic [15:0] max_samp = MAX_SAMPLES_RST;

	// shadow capture state
	mode_t       cap_mode = MODE_IDLE;
	int unsigned burst_cnt = 0;
	int unsigned bias_acc = 0;
	int unsigned bias_lvl = 0;
	int          win_sum = 0;
	int unsigned win_cnt = 0;
	int unsigned rate_phase = 0;
	int          dc_q8 = 0;
	logic [15:0] out_idx = '0;

	mic_item_t pending_items[$];
	mic_out_t  expected_samples[$];
	int        err_count = 0;
	int        results_seen = 0;
	int        item_count = 0;
	bit        hold_req = 1'b0;
	bit        no_idle = 1'b0;

	task automatic flag_error(input string msg);
		if (err_count < 100)
			$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic void clear_capture();
		burst_cnt  = 0;
		bias_acc   = 0;
		bias_lvl   = 0;
		win_sum    = 0;
		win_cnt    = 0;
		rate_phase = 0;
		dc_q8      = 0;
		out_idx    = '0;
	endfunction

	// works out the decimated dc-removed output caused by one item, if any
	function automatic void predict_sample(input mic_item_t it, output bit emit,
		output mic_out_t r);
		int v;
		int mean;
		int dc_int;
		int res;
		longint delta;
		bit due;
		logic [15:0] next_idx;
		emit = 1'b0;
		r = '0;
		if (it.act == ACT_START) begin
			clear_capture();
			cap_mode = MODE_BURST;
			return;
		end
		if (it.act == ACT_STOP) begin
			cap_mode = MODE_IDLE;
			return;
		end
		if (it.act != ACT_SAMPLE || cap_mode == MODE_IDLE)
			return;

		// bias burst
		if (cap_mode == MODE_BURST) begin
			bias_acc += it.adc;
			burst_cnt++;
			if (burst_cnt >= BURST_LEN) begin
				bias_lvl = bias_acc / BURST_LEN;
				cap_mode = MODE_RUN;
			end
			return;
		end

		// bias removal, clamp and window accumulation
		v = int'(it.adc) - int'(bias_lvl);
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		if (win_cnt < 65535) begin
			win_sum += v;
			win_cnt++;
		end

		// rate phase accumulator
		rate_phase += out_rate;
		due = 1'b0;
		if (src_rate == 0) begin
			due = 1'b1;
			rate_phase = 0;
		end else if (rate_phase >= src_rate) begin
			due = 1'b1;
			rate_phase -= src_rate;
			if (rate_phase >= src_rate)
				rate_phase = src_rate - 1;
		end
		if (!due)
			return;

		// window mean and dc tracker
		mean = win_sum / int'(win_cnt);
		delta = longint'(mean) * 256 - longint'(dc_q8);
		dc_q8 += int'(delta >>> POLE_SHIFT);
		dc_int = dc_q8 >>> 8;
		res = mean - dc_int;
		win_sum = 0;
		win_cnt = 0;

		emit = 1'b1;
		r.sample = res[15:0];
		r.index = out_idx;
		next_idx = out_idx + 16'd1;
		out_idx = next_idx;
		if (next_idx >= max_samp || next_idx == 16'd0) begin
			r.last = 1'b1;
			cap_mode = MODE_IDLE;
		end
	endfunction

	// input driver
	mic_item_t cur_item;
	always @(posedge clk or negedge arst_n) begin
		bit emit;
		mic_out_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_sample(cur_item, emit, r);
				if (emit)
					expected_samples.push_back(r);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur_item.adc;
					s_tuser  <= cur_item.act;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor with random back-pressure and one long hold-off
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		mic_out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_samples.size() == 0) begin
					flag_error($sformatf("unexpected transaction data %h last %b",
						m_tdata, m_tlast));
				end else begin
					want = expected_samples.pop_front();
					if (m_tdata[15:0] !== want.sample)
						flag_error($sformatf("sample %h, want %h (index %0d)",
							m_tdata[15:0], want.sample, want.index));
					if (m_tdata[31:16] !== want.index)
						flag_error($sformatf("sample_number %0d, want %0d",
							m_tdata[31:16], want.index));
					if (m_tlast !== want.last)
						flag_error($sformatf("last %b, want %b (index %0d)",
							m_tlast, want.last, want.index));
				end
			end
			if (hold_req && !hold_done) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(99) >= 23);
			end
		end
	end

	task automatic push_item(input logic [1:0] act, input logic [15:0] adc);
		mic_item_t it;
		it.act = act;
		it.adc = adc;
		pending_items.push_back(it);
		item_count++;
	endtask

	// wait until the block has nothing left to do
	task automatic drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// apb write: setup then access phase
	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_SOURCE_RATE: src_rate = val;
			REG_OUTPUT_RATE: out_rate = val;
			REG_MAX_SAMPLES: max_samp = val;
			default: ;
		endcase
	endtask

	task automatic cfg_all(input int src, input int outr, input int maxs);
		cfg_write(REG_SOURCE_RATE, src[15:0]);
		cfg_write(REG_OUTPUT_RATE, outr[15:0]);
		cfg_write(REG_MAX_SAMPLES, maxs[15:0]);
	endtask

	function automatic logic [15:0] near_level(input int centre, input int spread);
		int x;
		x = centre + int'($urandom_range(0, 2 * spread)) - spread;
		if (x < 0)
			x = 0;
		else if (x > 65535)
			x = 65535;
		return x[15:0];
	endfunction

	// one capture with random content and noise of random spread
	task automatic queue_capture();
		int centre;
		int spread;
		int n_run;
		centre = $urandom_range(0, 65535);
		case ($urandom_range(0, 2))
			0: spread = 64;
			1: spread = 4096;
			default: spread = 65535;
		endcase
		push_item(ACT_START, 16'($urandom_range(0, 65535)));
		// sometimes restart part way through the burst
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, BURST_LEN - 1))
				push_item(ACT_SAMPLE, near_level(centre, spread));
			push_item(ACT_START, 16'($urandom_range(0, 65535)));
		end
		repeat (BURST_LEN)
			push_item(ACT_SAMPLE, near_level(centre, spread));
		n_run = $urandom_range(8, 40);
		repeat (n_run) begin
			case ($urandom_range(0, 99))
				0: push_item(ACT_STOP, 16'($urandom_range(0, 65535)));
				1, 2, 3: push_item(ACT_UNUSED, 16'($urandom_range(0, 65535)));
				default: push_item(ACT_SAMPLE, near_level(centre, spread));
			endcase
		end
	endtask

	// run limit
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// stimulus
	initial begin
		int src;
		int outr;
		int maxs;
		int round;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle sample, unused code, stop, restart while busy
		push_item(ACT_SAMPLE, 16'hFFFF);
		push_item(ACT_UNUSED, 16'hAAAA);
		push_item(ACT_STOP, 16'h5555);
		push_item(ACT_START, 16'h0000);
		repeat (4) push_item(ACT_SAMPLE, 16'h1234);
		push_item(ACT_START, 16'hFFFF);
		// full-scale bias then low samples clamp negative
		repeat (BURST_LEN) push_item(ACT_SAMPLE, 16'hFFFF);
		push_item(ACT_SAMPLE, 16'h0000);
		push_item(ACT_SAMPLE, 16'h0000);
		push_item(ACT_SAMPLE, 16'hFFFF);
		push_item(ACT_SAMPLE, 16'hFFFF);
		push_item(ACT_SAMPLE, 16'h8000);
		push_item(ACT_SAMPLE, 16'h7FFF);
		push_item(ACT_STOP, 16'h0000);
		push_item(ACT_SAMPLE, 16'h0000);
		// zero bias then full-scale samples clamp positive
		push_item(ACT_START, 16'h0000);
		repeat (BURST_LEN) push_item(ACT_SAMPLE, 16'h0000);
		repeat (4) push_item(ACT_SAMPLE, 16'hFFFF);
		repeat (2) push_item(ACT_SAMPLE, 16'h0000);
		drain();

		// output rate above source rate, capture ends on max_samples
		cfg_all(5, 65535, 3);
		push_item(ACT_START, 16'h0000);
		repeat (BURST_LEN) push_item(ACT_SAMPLE, 16'h8000);
		repeat (6) push_item(ACT_SAMPLE, 16'($urandom_range(0, 65535)));
		drain();

		// source rate zero and max_samples zero
		cfg_all(0, 7, 0);
		push_item(ACT_START, 16'h0000);
		repeat (BURST_LEN) push_item(ACT_SAMPLE, 16'h4000);
		repeat (3) push_item(ACT_SAMPLE, 16'($urandom_range(0, 65535)));
		drain();

		// output rate zero: nothing comes out
		cfg_all(65535, 0, 65535);
		push_item(ACT_START, 16'h0000);
		repeat (BURST_LEN) push_item(ACT_SAMPLE, 16'($urandom_range(0, 65535)));
		repeat (10) push_item(ACT_SAMPLE, 16'($urandom_range(0, 65535)));
		push_item(ACT_STOP, 16'h0000);
		drain();

		// max_samples lowered below the count mid-capture
		cfg_all(1, 1, 65535);
		push_item(ACT_START, 16'h0000);
		repeat (BURST_LEN) push_item(ACT_SAMPLE, 16'($urandom_range(0, 65535)));
		repeat (6) push_item(ACT_SAMPLE, 16'($urandom_range(0, 65535)));
		drain();
		cfg_write(REG_MAX_SAMPLES, 16'd2);
		repeat (3) push_item(ACT_SAMPLE, 16'($urandom_range(0, 65535)));
		drain();

		// random rounds, each under a fresh register setting
		round = 0;
		while (item_count < 700 || round < 2) begin
			case ($urandom_range(0, 5))
				0: begin
					src = 16000;
					outr = 8000;
				end
				1: begin
					src = $urandom_range(1, 6);
					outr = $urandom_range(1, src);
				end
				2: begin
					src = 65535;
					outr = $urandom_range(0, 1) ? 65535 : 65534;
				end
				3: begin
					src = $urandom_range(1, 200);
					outr = $urandom_range(src, 65535);
				end
				4: begin
					src = $urandom_range(1, 65535);
					outr = src / int'($urandom_range(1, 6));
					if (outr == 0)
						outr = 1;
				end
				default: begin
					src = $urandom_range(2, 50);
					outr = $urandom_range(1, src);
				end
			endcase
			maxs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 65535;
			cfg_all(src, outr, maxs);
			if (round == 0)
				hold_req = 1'b1;
			no_idle = (round == 1);
			// carry on the previous capture under the new setting
			repeat ($urandom_range(2, 8))
				push_item(ACT_SAMPLE, 16'($urandom_range(0, 65535)));
			repeat ($urandom_range(1, 2)) queue_capture();
			drain();
			round++;
		end
		no_idle = 1'b0;

		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
design/mbdc_pkg.sv
design/mbdc_div.sv
design/mic_bias_decimate_dc_block_top.sv
tb/tb_mic_bias_decimate_dc_block_top.sv
